@@ hdl/glr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers of the glyph run layout block.
package glr_pkg;

	localparam int FIRST_CODE_DEF  = 32;
	localparam int GLYPH_COUNT_DEF = 95;

	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int LH_W   = 10;

	// Word index of the line height register.
	localparam logic [0:0] REG_LINE_HEIGHT = 1'b0;

	typedef enum logic [1:0] {
		REQ_GLYPH = 2'd0,
		REQ_KERN  = 2'd1,
		REQ_CHAR  = 2'd2,
		REQ_END   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_LINE   = 2'd1,
		KIND_HEIGHT = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [9:0] hor;
		logic signed [9:0] ver;
		logic [9:0]        adv;
		logic [9:0]        ht;
	} metrics_t;

	typedef struct packed {
		logic valid;
		req_t req;
		logic newline;
		logic apply_kern;
	} s1_ctl_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/glr_in_if.sv @@
`timescale 1ns / 1ps
// Request channel: table loads, characters and end-of-string markers.
interface glr_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [7:0]        char_code;
	logic [7:0]        pair_code;
	logic signed [9:0] hor_offset;
	logic signed [9:0] ver_offset;
	logic [9:0]        advance;
	logic [9:0]        glyph_height;
	logic signed [7:0] kern_value;

	modport source (output valid, req_type, char_code, pair_code, hor_offset, ver_offset,
		advance, glyph_height, kern_value, input ready);
	modport sink (input valid, req_type, char_code, pair_code, hor_offset, ver_offset,
		advance, glyph_height, kern_value, output ready);
endinterface

@@ hdl/glr_out_if.sv @@
`timescale 1ns / 1ps
// Record channel: draw positions, line widths and text heights.
interface glr_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         record_kind;
	logic signed [15:0] value_x;
	logic signed [15:0] value_y;
	logic [7:0]         line_number;
	logic               last;

	modport source (output valid, record_kind, value_x, value_y, line_number, last,
		input ready);
	modport sink (input valid, record_kind, value_x, value_y, line_number, last,
		output ready);
endinterface

@@ hdl/glr_apb.sv @@
`timescale 1ns / 1ps
// APB register file holding the line pitch.
module glr_apb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [glr_pkg::APB_AW-1:0]  paddr,
	input  logic [glr_pkg::APB_DW-1:0]  pwdata,
	output logic [glr_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [glr_pkg::LH_W-1:0]    line_pitch
);
	import glr_pkg::*;

	logic [LH_W-1:0] line_pitch_q;
	logic            wr_en;
	logic            hit;

	assign pready = 1'b1;
	assign hit    = (paddr[APB_AW-1:2] == REG_LINE_HEIGHT);
	assign wr_en  = psel && penable && pwrite && pready && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pitch_q <= '0;
		end else if (wr_en) begin
			line_pitch_q <= pwdata[LH_W-1:0];
		end
	end

	assign prdata     = hit ? APB_DW'(line_pitch_q) : '0;
	assign line_pitch = line_pitch_q;
endmodule

@@ hdl/glr_front.sv @@
`timescale 1ns / 1ps
// Request decode, metric and kerning memories, and the read stage.
module glr_front #(
	parameter int FIRST_CODE  = glr_pkg::FIRST_CODE_DEF,
	parameter int GLYPH_COUNT = glr_pkg::GLYPH_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	glr_in_if.sink              chars,
	input  logic                s1_done,
	output glr_pkg::s1_ctl_t    ctl_s1,
	output glr_pkg::metrics_t   metrics_s1,
	output logic signed [7:0]   kern_s1
);
	import glr_pkg::*;

	localparam int GIDX_W  = $clog2(GLYPH_COUNT);
	localparam int KDEPTH  = GLYPH_COUNT * GLYPH_COUNT;
	localparam int KADDR_W = $clog2(KDEPTH);
	localparam logic [7:0] FC = 8'(FIRST_CODE);
	localparam bit SP_IN = (int'(SPACE_CODE) >= FIRST_CODE) &&
		(int'(SPACE_CODE) - FIRST_CODE < GLYPH_COUNT);
	localparam logic [GIDX_W-1:0] SP_IDX =
		GIDX_W'(SP_IN ? int'(SPACE_CODE) - FIRST_CODE : 0);

	metrics_t          mem_metrics [GLYPH_COUNT];
	logic signed [7:0] mem_kern [KDEPTH];

	logic [GIDX_W-1:0]  prev_q;
	logic               on_line_q;

	req_t               req;
	logic               accept;
	logic               s1_free;
	logic [7:0]         code_off;
	logic [7:0]         pair_off;
	logic               code_hit;
	logic               pair_hit;
	logic [GIDX_W-1:0]  code_idx;
	logic [GIDX_W-1:0]  pair_idx;
	logic [GIDX_W-1:0]  g_eff;
	logic [GIDX_W-1:0]  mrd_addr;
	logic [KADDR_W-1:0] krd_addr;
	logic [KADDR_W-1:0] kwr_addr;
	logic               is_nl;

	assign req      = req_t'(chars.req_type);
	assign s1_free  = !ctl_s1.valid || s1_done;
	assign chars.ready = s1_free;
	assign accept   = chars.valid && s1_free;

	assign code_off = chars.char_code - FC;
	assign pair_off = chars.pair_code - FC;
	assign code_hit = (chars.char_code >= FC) && ({1'b0, code_off} < 9'(GLYPH_COUNT));
	assign pair_hit = (chars.pair_code >= FC) && ({1'b0, pair_off} < 9'(GLYPH_COUNT));
	assign code_idx = code_off[GIDX_W-1:0];
	assign pair_idx = pair_off[GIDX_W-1:0];
	assign g_eff    = code_hit ? code_idx : SP_IDX;
	assign is_nl    = (req == REQ_CHAR) && (chars.char_code == NEWLINE_CODE);

	// End of string reads the space glyph for the empty-line defaults.
	assign mrd_addr = (req == REQ_CHAR) ? g_eff : SP_IDX;
	assign krd_addr = KADDR_W'(int'(g_eff) * GLYPH_COUNT + int'(prev_q));
	assign kwr_addr = KADDR_W'(int'(code_idx) * GLYPH_COUNT + int'(pair_idx));

	always_ff @(posedge clk) begin
		if (accept && req == REQ_GLYPH && code_hit) begin
			mem_metrics[code_idx] <= '{hor: chars.hor_offset, ver: chars.ver_offset,
				adv: chars.advance, ht: chars.glyph_height};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req == REQ_KERN && code_hit && pair_hit) begin
			mem_kern[kwr_addr] <= chars.kern_value;
		end
	end

	// Read data stays put while the pen stage stalls, since reads follow accepts.
	always_ff @(posedge clk) begin
		if (accept) begin
			metrics_s1 <= mem_metrics[mrd_addr];
			kern_s1    <= mem_kern[krd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			prev_q    <= '0;
			on_line_q <= 1'b0;
		end else begin
			if (s1_free) begin
				ctl_s1.valid      <= accept;
				ctl_s1.req        <= req;
				ctl_s1.newline    <= is_nl;
				ctl_s1.apply_kern <= on_line_q;
			end
			if (accept) begin
				case (req)
					REQ_CHAR: begin
						if (is_nl) begin
							on_line_q <= 1'b0;
						end else begin
							prev_q    <= g_eff;
							on_line_q <= 1'b1;
						end
					end
					REQ_END: begin
						prev_q    <= '0;
						on_line_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end
endmodule

@@ hdl/glr_pen.sv @@
`timescale 1ns / 1ps
// Pen accumulator, line extents and the output record register.
module glr_pen (
	input  logic                           clk,
	input  logic                           arst_n,
	input  glr_pkg::s1_ctl_t               ctl_s1,
	input  glr_pkg::metrics_t              metrics_s1,
	input  logic signed [7:0]              kern_s1,
	input  logic [glr_pkg::LH_W-1:0]       line_pitch,
	glr_out_if.source                      records,
	output logic                           s1_done
);
	import glr_pkg::*;

	logic signed [15:0] pen_x_q;
	logic signed [15:0] pen_y_q;
	logic [7:0]         line_q;
	logic signed [9:0]  fmin_q;
	logic               fmin_set_q;
	logic signed [11:0] lmax_q;
	logic               lmax_set_q;
	logic               phase_q;

	logic               out_v_q;
	kind_t              kind_q;
	logic signed [15:0] x_q;
	logic signed [15:0] y_q;
	logic [7:0]         ln_q;
	logic               last_q;

	logic               out_free;
	logic               is_char;
	logic               is_nl;
	logic               is_end;
	logic               is_load;
	logic               emit;
	logic signed [17:0] px18;
	logic signed [17:0] py18;
	logic signed [17:0] kern18;
	logic signed [17:0] hor18;
	logic signed [17:0] ver18;
	logic signed [17:0] adv18;
	logic signed [17:0] lh18;
	logic signed [15:0] px_kern;
	logic signed [17:0] pxk18;
	logic signed [15:0] draw_x;
	logic signed [15:0] draw_y;
	logic signed [15:0] next_x;
	logic signed [15:0] next_y;
	logic signed [11:0] ver12;
	logic signed [11:0] ht12;
	logic signed [11:0] hsum12;
	logic signed [17:0] hmin18;
	logic signed [17:0] hmax18;
	logic signed [15:0] height;

	assign out_free = !out_v_q || records.ready;
	assign is_load  = ctl_s1.valid && (ctl_s1.req == REQ_GLYPH || ctl_s1.req == REQ_KERN);
	assign is_char  = ctl_s1.valid && ctl_s1.req == REQ_CHAR && !ctl_s1.newline;
	assign is_nl    = ctl_s1.valid && ctl_s1.req == REQ_CHAR && ctl_s1.newline;
	assign is_end   = ctl_s1.valid && ctl_s1.req == REQ_END;
	assign emit     = (is_char || is_nl || is_end) && out_free;
	// End of string holds the stage for a second beat.
	assign s1_done  = is_load || (emit && (!is_end || phase_q));

	assign px18   = pen_x_q;
	assign py18   = pen_y_q;
	assign kern18 = kern_s1;
	assign hor18  = metrics_s1.hor;
	assign ver18  = metrics_s1.ver;
	assign adv18  = 18'(metrics_s1.adv);
	assign lh18   = 18'(line_pitch);

	assign px_kern = ctl_s1.apply_kern ? sat16(px18 + kern18) : pen_x_q;
	assign pxk18   = px_kern;
	assign draw_x  = sat16(pxk18 + hor18);
	assign draw_y  = sat16(py18 + ver18);
	assign next_x  = sat16(pxk18 + adv18);
	assign next_y  = sat16(py18 + lh18);

	assign ver12  = metrics_s1.ver;
	assign ht12   = 12'(metrics_s1.ht);
	assign hsum12 = ver12 + ht12;

	assign hmin18 = fmin_set_q ? 18'(fmin_q) : ver18;
	assign hmax18 = lmax_set_q ? 18'(lmax_q) : 18'(hsum12);
	assign height = sat16(hmin18 + py18 + hmax18);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q    <= '0;
			pen_y_q    <= '0;
			line_q     <= '0;
			fmin_q     <= '0;
			fmin_set_q <= 1'b0;
			lmax_q     <= '0;
			lmax_set_q <= 1'b0;
			phase_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (out_free) begin
				out_v_q <= emit;
			end
			if (emit && is_char) begin
				pen_x_q <= next_x;
				if (line_q == '0 && (!fmin_set_q || metrics_s1.ver < fmin_q)) begin
					fmin_q <= metrics_s1.ver;
				end
				if (line_q == '0) begin
					fmin_set_q <= 1'b1;
				end
				if (!lmax_set_q || hsum12 > lmax_q) begin
					lmax_q <= hsum12;
				end
				lmax_set_q <= 1'b1;
			end
			if (emit && is_nl) begin
				pen_x_q    <= '0;
				pen_y_q    <= next_y;
				lmax_q     <= '0;
				lmax_set_q <= 1'b0;
				if (line_q != 8'hFF) begin
					line_q <= line_q + 8'd1;
				end
			end
			if (emit && is_end) begin
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					phase_q    <= 1'b0;
					pen_x_q    <= '0;
					pen_y_q    <= '0;
					line_q     <= '0;
					fmin_q     <= '0;
					fmin_set_q <= 1'b0;
					lmax_q     <= '0;
					lmax_set_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ln_q <= line_q;
			if (is_char) begin
				kind_q <= KIND_CHAR;
				x_q    <= draw_x;
				y_q    <= draw_y;
				last_q <= 1'b0;
			end else if (is_end && phase_q) begin
				kind_q <= KIND_HEIGHT;
				x_q    <= height;
				y_q    <= '0;
				last_q <= 1'b1;
			end else begin
				kind_q <= KIND_LINE;
				x_q    <= pen_x_q;
				y_q    <= '0;
				last_q <= 1'b0;
			end
		end
	end

	assign records.valid       = out_v_q;
	assign records.record_kind = kind_q;
	assign records.value_x     = x_q;
	assign records.value_y     = y_q;
	assign records.line_number = ln_q;
	assign records.last        = last_q;
endmodule

@@ hdl/glyph_run_layout.sv @@
`timescale 1ns / 1ps
// Pipeline: each request passes the memory read stage, then the pen stage's output record register.
// Throughput: one request per cycle while records.ready is high; an end-of-string request
// holds the pen stage for its two records, as the pen stage writes a single output register.
// Reset: arst_n clears the pen, line state, pipeline valids and the line pitch at once;
// glyph metrics and kerning memories are not cleared and must be loaded before use.
module glyph_run_layout #(
	parameter int FIRST_CODE  = glr_pkg::FIRST_CODE_DEF,
	parameter int GLYPH_COUNT = glr_pkg::GLYPH_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	glr_in_if.sink                      chars,
	glr_out_if.source                   records,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [glr_pkg::APB_AW-1:0]  paddr,
	input  logic [glr_pkg::APB_DW-1:0]  pwdata,
	output logic [glr_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import glr_pkg::*;

	s1_ctl_t           ctl_s1;
	metrics_t          metrics_s1;
	logic signed [7:0] kern_s1;
	logic              s1_done;
	logic [LH_W-1:0]   line_pitch;

	glr_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.line_pitch (line_pitch)
	);

	glr_front #(
		.FIRST_CODE  (FIRST_CODE),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.s1_done    (s1_done),
		.ctl_s1     (ctl_s1),
		.metrics_s1 (metrics_s1),
		.kern_s1    (kern_s1)
	);

	glr_pen u_pen (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.metrics_s1 (metrics_s1),
		.kern_s1    (kern_s1),
		.line_pitch (line_pitch),
		.records    (records),
		.s1_done    (s1_done)
	);
endmodule

@@ hdl/glr_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the record channel, bound to the top level.
module glr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rec_valid,
	input logic        rec_ready,
	input logic [1:0]  rec_kind,
	input logic [15:0] rec_x,
	input logic [15:0] rec_y,
	input logic [7:0]  rec_line,
	input logic        rec_last
);
	import glr_pkg::*;

	logic [1:0] prev_kind_q;
	logic [7:0] prev_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_kind_q <= KIND_CHAR;
			prev_line_q <= '0;
		end else if (rec_valid && rec_ready) begin
			prev_kind_q <= rec_kind;
			prev_line_q <= rec_line;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid &&
		$stable({rec_kind, rec_x, rec_y, rec_line, rec_last}))
		else $error("record changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (rec_last == (rec_kind == KIND_HEIGHT)))
		else $error("last flag does not match the height record");

	a_zero_y: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_kind != KIND_CHAR |-> rec_y == '0)
		else $error("nonzero y on a width or height record");

	a_height_order: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready && rec_kind == KIND_HEIGHT |->
		prev_kind_q == KIND_LINE && prev_line_q == rec_line)
		else $error("height beat not preceded by the last line width");
endmodule

bind glyph_run_layout glr_checker u_glr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rec_valid (records.valid),
	.rec_ready (records.ready),
	.rec_kind  (records.record_kind),
	.rec_x     (records.value_x),
	.rec_y     (records.value_y),
	.rec_line  (records.line_number),
	.rec_last  (records.last)
);
